/* hw/rtl/pst_pkg.sv */
// Shared types, constants and helpers for the polyline segment unit tangent block.
// No dependencies.
`default_nettype none
package pst_pkg;
   localparam int COORD_WIDTH_DEF   = 32;
   localparam int DIR_FRAC_BITS_DEF = 14;
   localparam int FIELD_W   = 32;
   localparam int DIR_W     = 16;
   localparam int DIR_MAX   = 32767;
   localparam int MAG_W     = 16;
   localparam int SQ_W      = 34;
   localparam int RAD_W     = 62;
   localparam int ROOT_W    = 31;
   localparam int ROOT_STEPS = 31;
   localparam int CNT_W     = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MAX,
      ST_NORM,
      ST_SQ,
      ST_ROOT,
      ST_DIVLD,
      ST_DIV,
      ST_EMIT_A,
      ST_EMIT_B
   } state_type;

   typedef struct packed {
      state_type  state;
      logic [1:0] idx;
      logic       last_step;
   } ctrl_type;

   typedef struct packed {
      logic m_zero;
      logic m_high;
      logic m_low;
   } stat_type;

   function automatic logic [DIR_W-1:0] unit_code(input int frac);
      logic [DIR_W-1:0] u;
      if (frac >= 15) begin
         u = DIR_W'(DIR_MAX);
      end else begin
         u = DIR_W'(1 << frac);
      end
      return u;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/pst_seq.sv */
// Sequencer for the shared arithmetic unit: diff, normalize, square sum, root, divide, emit.
// Depends on pst_pkg.
`default_nettype none
module pst_seq
   import pst_pkg::*;
#(
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_fire,
   input  wire logic     req_end,
   input  wire logic     have_prev,
   input  wire logic     end_hold,
   input  wire logic     out_free,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);
   localparam int QB = DIR_FRAC_BITS + 2;

   state_type        state_ff, state_in;
   logic [1:0]       idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             root_last, div_last;

   assign root_last = (cnt_ff == CNT_W'(ROOT_STEPS - 1));
   assign div_last  = (cnt_ff == CNT_W'(QB - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            cnt_in = '0;
            if (req_fire) begin
               if (have_prev) begin
                  state_in = ST_DIFF;
               end else if (req_end) begin
                  state_in = ST_EMIT_B;
               end
            end
         end
         ST_DIFF: begin
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               state_in = ST_MAX;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_MAX: state_in = ST_NORM;
         ST_NORM: begin
            if (stat.m_zero) begin
               state_in = ST_EMIT_A;
            end else if (!stat.m_high && !stat.m_low) begin
               idx_in   = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (idx_ff == 2'd2) begin
               idx_in   = '0;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         ST_ROOT: begin
            if (root_last) begin
               cnt_in   = '0;
               idx_in   = '0;
               state_in = ST_DIVLD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DIVLD: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) begin
               if (idx_ff == 2'd2) begin
                  state_in = ST_EMIT_A;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_DIVLD;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_EMIT_A: begin
            if (out_free) begin
               state_in = end_hold ? ST_EMIT_B : ST_IDLE;
            end
         end
         ST_EMIT_B: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ctrl.state     = state_ff;
      ctrl.idx       = idx_ff;
      ctrl.last_step = (state_ff == ST_ROOT && root_last) || (state_ff == ST_DIV && div_last);
   end
endmodule
`default_nettype wire

/* hw/rtl/pst_core.sv */
// Datapath: segment difference, block normalize, square sum, bit-serial root and divider.
// Depends on pst_pkg; driven by pst_seq.
`default_nettype none
module pst_core
   import pst_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire ctrl_type                      ctrl,
   input  wire logic signed [COORD_WIDTH-1:0] cur_pt  [3],
   input  wire logic signed [COORD_WIDTH-1:0] prev_pt [3],
   output stat_type                           stat,
   output logic signed [DIR_W-1:0]            dir     [3]
);
   localparam int DW   = COORD_WIDTH + 1;
   localparam int QB   = DIR_FRAC_BITS + 2;
   localparam int NUMW = MAG_W + DIR_FRAC_BITS + 14 + 1;
   localparam logic [QB-1:0] UNIT_Q = QB'(unit_code(DIR_FRAC_BITS));

   logic [DW-1:0]           mag_ff [3];
   logic                    sign_ff [3];
   logic [DW-1:0]           m_ff;
   logic [SQ_W-1:0]         acc_ff, acc_in;
   logic [RAD_W-1:0]        rad_ff;
   logic [ROOT_W+1:0]       rrem_ff;
   logic [ROOT_W-1:0]       root_ff;
   logic [ROOT_W-1:0]       drem_ff;
   logic [QB-1:0]           nlow_ff, quo_ff;
   logic signed [DIR_W-1:0] dir_ff [3];

   logic signed [DW-1:0] diff;
   logic [DW-1:0]        max01, max012;
   logic [MAG_W-1:0]     a_sel;
   logic [2*MAG_W-1:0]   sq;
   logic [ROOT_W+3:0]    rem2, trial;
   logic                 rbit;
   logic [NUMW-1:0]      num;
   logic [ROOT_W:0]      r2;
   logic                 qbit;
   logic [QB-1:0]        quo_fin, qc;
   logic [DIR_W-1:0]     qmag;

   always_comb begin
      diff   = {cur_pt[ctrl.idx][COORD_WIDTH-1], cur_pt[ctrl.idx]}
             - {prev_pt[ctrl.idx][COORD_WIDTH-1], prev_pt[ctrl.idx]};
      max01  = (mag_ff[1] > mag_ff[0]) ? mag_ff[1] : mag_ff[0];
      max012 = (mag_ff[2] > max01) ? mag_ff[2] : max01;
      a_sel  = mag_ff[ctrl.idx][MAG_W-1:0];
      sq     = a_sel * a_sel;
      acc_in = ((ctrl.idx == 2'd0) ? '0 : acc_ff) + SQ_W'(sq);
      rem2   = {rrem_ff, rad_ff[RAD_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      rbit   = (rem2 >= trial);
      num    = NUMW'({a_sel, {(DIR_FRAC_BITS + 14){1'b0}}})
             + NUMW'(root_ff[ROOT_W-1:1]);
      r2     = {drem_ff, nlow_ff[QB-1]};
      qbit   = (r2 >= {1'b0, root_ff});
      quo_fin = {quo_ff[QB-2:0], qbit};
      qc     = (quo_fin > UNIT_Q) ? UNIT_Q : quo_fin;
      qmag   = DIR_W'(qc);
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.state)
         ST_DIFF: begin
            sign_ff[ctrl.idx] <= diff[DW-1];
            mag_ff[ctrl.idx]  <= diff[DW-1] ? DW'(-diff) : DW'(diff);
         end
         ST_MAX: m_ff <= max012;
         ST_NORM: begin
            if (stat.m_zero) begin
               for (int i = 0; i < 3; i++) begin
                  dir_ff[i] <= '0;
               end
            end else if (stat.m_high) begin
               m_ff <= m_ff >> 1;
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end else if (stat.m_low) begin
               m_ff <= m_ff << 1;
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         ST_SQ: begin
            acc_ff <= acc_in;
            if (ctrl.idx == 2'd2) begin
               rad_ff  <= {acc_in, 28'b0};
               rrem_ff <= '0;
               root_ff <= '0;
            end
         end
         ST_ROOT: begin
            rad_ff  <= rad_ff << 2;
            rrem_ff <= rbit ? (ROOT_W+2)'(rem2 - trial) : (ROOT_W+2)'(rem2);
            root_ff <= {root_ff[ROOT_W-2:0], rbit};
         end
         ST_DIVLD: begin
            drem_ff <= ROOT_W'(num[NUMW-1:QB]);
            nlow_ff <= num[QB-1:0];
            quo_ff  <= '0;
         end
         ST_DIV: begin
            drem_ff <= qbit ? ROOT_W'(r2 - {1'b0, root_ff}) : ROOT_W'(r2);
            nlow_ff <= nlow_ff << 1;
            quo_ff  <= quo_fin;
            if (ctrl.last_step) begin
               dir_ff[ctrl.idx] <= sign_ff[ctrl.idx] ? -$signed(qmag) : $signed(qmag);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      stat.m_zero = (m_ff == '0);
      stat.m_high = |m_ff[DW-1:MAG_W];
      stat.m_low  = (m_ff[DW-1:MAG_W-1] == '0);
      for (int i = 0; i < 3; i++) begin
         dir[i] = dir_ff[i];
      end
   end
endmodule
`default_nettype wire

/* hw/rtl/polyline_segment_unit_tangent.sv */
// Top level: stream ports, point and held-direction registers, result register.
// Depends on pst_pkg, pst_seq, pst_core.
//
//  channel | dir | tdata                         | tuser       | tlast
//  req     | in  | point_x, point_y, point_z     | -           | fiber_end
//  rsp     | out | dir_x, dir_y, dir_z           | zero_length | last_of_run
//
// A point after an earlier one runs, from accept back to ready, through: a diff per axis,
// max, normalize (one bit shift a cycle), a square per axis, 31 root steps, three divides
// (each a load and a bit-serial divide) and one emit. A zero-length segment skips square, root and divide.
// A first point only loads the point registers; a lone point emits the held direction; a fiber end adds a repeat.
// Reset is synchronous; held direction resets to 1.0.
// A stalled result holds in the output register; no new item is taken while busy.
`default_nettype none
module polyline_segment_unit_tangent
   import pst_pkg::*;
#(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = DIR_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,  // point_x, point_y, point_z
   input  wire logic        req_tlast,  // fiber_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // dir_x, dir_y, dir_z
   output logic             rsp_tuser,  // zero_length
   output logic             rsp_tlast   // last_of_run
);
   localparam logic [DIR_W-1:0] UNIT = unit_code(DIR_FRAC_BITS);

   ctrl_type ctrl;
   stat_type stat;

   logic signed [COORD_WIDTH-1:0] coord   [3];
   logic signed [COORD_WIDTH-1:0] cur_ff  [3];
   logic signed [COORD_WIDTH-1:0] prev_ff [3];
   logic signed [DIR_W-1:0]       dir     [3];
   logic [DIR_W-1:0]              held_ff [3];
   logic                          held_zero_ff;
   logic                          have_prev_ff;
   logic                          end_ff;
   logic                          rsp_tvalid_ff;
   logic [47:0]                   rsp_tdata_ff;
   logic                          rsp_tuser_ff, rsp_tlast_ff;
   logic                          req_fire, out_free, emit_a, emit_b;

   for (genvar i = 0; i < 3; i++) begin : g_coord
      if (COORD_WIDTH <= FIELD_W) begin : g_narrow
         assign coord[i] = req_tdata[i*FIELD_W +: COORD_WIDTH];
      end else begin : g_wide
         assign coord[i] = {{(COORD_WIDTH - FIELD_W){1'b0}}, req_tdata[i*FIELD_W +: FIELD_W]};
      end
   end

   assign req_tready = (ctrl.state == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign emit_a     = (ctrl.state == ST_EMIT_A) && out_free;
   assign emit_b     = (ctrl.state == ST_EMIT_B) && out_free;

   pst_seq #(
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_end   (req_tlast),
      .have_prev (have_prev_ff),
      .end_hold  (end_ff),
      .out_free  (out_free),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   pst_core #(
      .COORD_WIDTH   (COORD_WIDTH),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_core (
      .clock   (clock),
      .ctrl    (ctrl),
      .cur_pt  (cur_ff),
      .prev_pt (prev_ff),
      .stat    (stat),
      .dir     (dir)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         held_zero_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= UNIT;
         end
      end else begin
         if (emit_a || emit_b) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (req_fire) begin
            end_ff <= req_tlast;
            for (int i = 0; i < 3; i++) begin
               cur_ff[i] <= coord[i];
            end
            if (!have_prev_ff) begin
               have_prev_ff <= !req_tlast;
               for (int i = 0; i < 3; i++) begin
                  prev_ff[i] <= coord[i];
               end
            end
         end
         if (emit_a) begin
            have_prev_ff  <= !end_ff;
            held_zero_ff  <= stat.m_zero;
            rsp_tdata_ff  <= {dir[2], dir[1], dir[0]};
            rsp_tuser_ff  <= stat.m_zero;
            rsp_tlast_ff  <= !end_ff;
            for (int i = 0; i < 3; i++) begin
               held_ff[i] <= dir[i];
               prev_ff[i] <= cur_ff[i];
            end
         end
         if (emit_b) begin
            rsp_tdata_ff  <= {held_ff[2], held_ff[1], held_ff[0]};
            rsp_tuser_ff  <= held_zero_ff;
            rsp_tlast_ff  <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_start_compute: assert property (@(posedge clock) disable iff (reset)
      (req_fire && have_prev_ff) |=> (ctrl.state == ST_DIFF))
      else $error("segment item did not start the datapath");
   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (ctrl.state == ST_EMIT_A && stat.m_zero) |-> (dir[0] == '0 && dir[1] == '0 && dir[2] == '0))
      else $error("zero-length segment with nonzero direction");
   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      held_zero_ff |-> (held_ff[0] == '0 && held_ff[1] == '0 && held_ff[2] == '0))
      else $error("held zero flag with nonzero held direction");
`endif
endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench for polyline_segment_unit_tangent: streams 3D polyline points and checks
// each unit-direction result against an in-bench predictor of the normalization.
// Depends on pst_pkg and the polyline_segment_unit_tangent RTL.
`timescale 1ns / 100ps
module tb;
   import pst_pkg::*;

   localparam int FRAC = DIR_FRAC_BITS_DEF;
   localparam int LIMIT = 2_000_000;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
      logic        zero_len;
      logic        last;
   } tangent_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   polyline_segment_unit_tangent dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [63:0] prev_pt [3];
   logic               have_prev;
   logic signed [31:0] held_dir [3];
   logic               held_zero;

   tangent_type tangent_q[$];
   int          errors = 0;
   int          cycles = 0;
   int          burst_left = 0;

   task automatic report(input string what, input tangent_type got, input tangent_type want);
      $display("tb: mismatch %s got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] isqrt(input logic [63:0] n);
      logic [63:0] res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] enc(input logic signed [31:0] v);
      return v[15:0];
   endfunction

   task automatic normalize(input logic signed [63:0] d [3]);
      logic [63:0] mag [3];
      logic [63:0] m, s, r, q, one;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = d[i] < 0 ? -d[i] : d[i];
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         held_dir = '{0, 0, 0};
         held_zero = 1'b1;
         return;
      end
      while (m >= 64'd65536) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < 64'd32768) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      r = isqrt(s << 28);
      one = 64'd1 << FRAC;
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << (FRAC + 14)) + (r >> 1)) / r;
         if (q > one) q = one;
         if (q > DIR_MAX) q = DIR_MAX;
         held_dir[i] = d[i] < 0 ? -$signed(q[31:0]) : $signed(q[31:0]);
      end
      held_zero = 1'b0;
   endtask

   task automatic predict_tangents(input logic [31:0] px, py, pz, input logic fend);
      logic signed [63:0] cur [3];
      logic signed [63:0] d [3];
      cur[0] = $signed(px);
      cur[1] = $signed(py);
      cur[2] = $signed(pz);
      if (have_prev) begin
         for (int i = 0; i < 3; i++) d[i] = cur[i] - prev_pt[i];
         normalize(d);
         tangent_q.push_back({enc(held_dir[0]), enc(held_dir[1]), enc(held_dir[2]),
                              held_zero, !fend});
      end
      prev_pt = cur;
      have_prev = 1'b1;
      if (fend) begin
         tangent_q.push_back({enc(held_dir[0]), enc(held_dir[1]), enc(held_dir[2]),
                              held_zero, 1'b1});
         have_prev = 1'b0;
      end
   endtask

   // sender idles in bursts with random gaps
   task automatic send_point(input logic [31:0] px, py, pz, input logic fend);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pz, py, px};
      req_tlast <= fend;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_tangents(px, py, pz, fend);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tangent_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 3) - 2;
         2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      endcase
   endfunction

   task automatic test_directed();
      send_point(0, 0, 0, 1'b1);                                 // lone point: reset held dir
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0); // zero length
      send_point(32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_point(5, 5, 5, 1'b0);
      send_point(5, 5, 5, 1'b1);                                 // zero length at end
      send_point(1, 2, 3, 1'b1);                                 // lone point after zero
      send_point(0, 0, 0, 1'b0);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_point(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
      send_point(32'hFFFF_0000, 32'h0000_0001, 32'h0001_0000, 1'b1);
      send_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b0);
      send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hEDCB_A987, 1'b1);
   endtask

   task automatic test_pause();
      drain();
      send_point(7, 8, 9, 1'b0);
      send_point(70, 8, 9, 1'b1);
   endtask

   task automatic test_random();
      int fiber_len;
      int sent;
      sent = 0;
      while (sent < 750) begin
         fiber_len = $urandom_range(0, 7) == 0 ? 1 : $urandom_range(2, 8);
         for (int k = 0; k < fiber_len; k++) begin
            send_point(rand_coord(), rand_coord(), rand_coord(), k == fiber_len - 1);
            sent++;
         end
      end
   endtask

   // receiver stall pattern, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (cycles % 2000) < 600 ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      tangent_type got, want;
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser, rsp_tlast};
         if (tangent_q.size() == 0) begin
            report("unexpected item", got, '0);
         end else begin
            want = tangent_q.pop_front();
            if (got.x !== want.x) report("dir_x", got, want);
            if (got.y !== want.y) report("dir_y", got, want);
            if (got.z !== want.z) report("dir_z", got, want);
            if (got.zero_len !== want.zero_len) report("zero_length", got, want);
            if (got.last !== want.last) report("last_of_run", got, want);
         end
      end
      if (cycles > LIMIT) begin
         $display("tb: timeout");
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      prev_pt = '{0, 0, 0};
      have_prev = 1'b0;
      held_dir = '{1 << FRAC, 1 << FRAC, 1 << FRAC};
      if (FRAC >= 15) held_dir = '{DIR_MAX, DIR_MAX, DIR_MAX};
      held_zero = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pause();
      test_random();
      drain();
      if (errors == 0 && tangent_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end
endmodule
